[rtl/fcca_pkg.sv]
// Shared types and constants for the cluster chain allocator.
// Used by every RTL file of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fcca_pkg;

	// Table geometry
	localparam int TABLE_ENTRIES = 1024;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = IDX_W + 1;

	// Channel field widths
	localparam int CMD_W     = 2;
	localparam int CLUSTER_W = 10;
	localparam int COUNT_W   = 11;
	localparam int LINK_W    = 28;
	localparam int STATUS_W  = 2;
	localparam int SECTOR_W  = 18;
	localparam int DONE_W    = 11;

	// Configuration register widths
	localparam int CC_W  = 11;
	localparam int DSS_W = 16;
	localparam int SPC_W = 8;

	// APB port
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 4;

	// Register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_CLUSTER_COUNT       = 2'd0;
	localparam logic [1:0] REG_DATA_START_SECTOR   = 2'd1;
	localparam logic [1:0] REG_SECTORS_PER_CLUSTER = 2'd2;

	localparam logic [CC_W-1:0]  CC_RESET  = 11'd1024;
	localparam logic [DSS_W-1:0] DSS_RESET = 16'd0;
	localparam logic [SPC_W-1:0] SPC_RESET = 8'd8;

	// Link words
	localparam logic [LINK_W-1:0] END_MARK  = 28'hFFFFFFF;
	localparam logic [LINK_W-1:0] FREE_MARK = 28'h0000000;

	localparam logic [SECTOR_W-1:0] SECTOR_MAX = '1;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_READ  = 2'd2,
		CMD_WRITE = 2'd3
	} cmd_code_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_BAD_ARG  = 2'd1,
		ST_NO_SPACE = 2'd2,
		ST_BROKEN   = 2'd3
	} status_t;

	typedef struct packed {
		logic [CC_W-1:0]  cluster_count;
		logic [DSS_W-1:0] data_start_sector;
		logic [SPC_W-1:0] sectors_per_cluster;
	} cfg_t;

	// Datapath operation for the current cycle
	typedef enum logic [2:0] {
		OP_NOP      = 3'd0,
		OP_CLEAR    = 3'd1,
		OP_START    = 3'd2,
		OP_COUNT    = 3'd3,
		OP_RESCAN   = 3'd4,
		OP_LINK     = 3'd5,
		OP_LINK_END = 3'd6,
		OP_WALK     = 3'd7
	} dp_op_t;

	// Which result to build into the output register
	typedef enum logic [2:0] {
		RK_BAD     = 3'd0,
		RK_NOSPACE = 3'd1,
		RK_BROKEN  = 3'd2,
		RK_READ    = 3'd3,
		RK_WRITE   = 3'd4,
		RK_ALLOC   = 3'd5,
		RK_FREED   = 3'd6
	} res_kind_t;

	typedef struct packed {
		dp_op_t    op;
		logic      load_item;
		logic      res_load;
		res_kind_t kind;
	} dp_cmd_t;

	typedef struct packed {
		cmd_code_t command;
		logic      arg_ok;
		logic      count_zero;
		logic      clr_last;
		logic      enough;
		logic      scan_done;
		logic      walk_over;
		logic      walk_end;
		logic      walk_bad;
	} dp_stat_t;

endpackage

`default_nettype wire

[rtl/fcca_channels.sv]
// Valid/ready channel interfaces for commands and results.
// Depends on fcca_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface fcca_cmd_if import fcca_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     command;
	logic [CLUSTER_W-1:0] cluster;
	logic [COUNT_W-1:0]   count;
	logic [LINK_W-1:0]    link_value;

	modport source (output valid, command, cluster, count, link_value, input ready);
	modport sink   (input valid, command, cluster, count, link_value, output ready);
endinterface

interface fcca_res_if import fcca_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [CLUSTER_W-1:0] result_cluster;
	logic [LINK_W-1:0]    result_link;
	logic [SECTOR_W-1:0]  sector;
	logic [DONE_W-1:0]    done_count;

	modport source (output valid, status, result_cluster, result_link, sector, done_count,
		input ready);
	modport sink   (input valid, status, result_cluster, result_link, sector, done_count,
		output ready);
endinterface

`default_nettype wire

[rtl/fcca_regs.sv]
// APB configuration registers: cluster count, data start sector, sectors per cluster.
// Depends on fcca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcca_regs import fcca_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	cfg_t       cfg_q;
	logic [1:0] index;
	logic       wr_en;

	assign index  = paddr[APB_ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cluster_count       <= CC_RESET;
			cfg_q.data_start_sector   <= DSS_RESET;
			cfg_q.sectors_per_cluster <= SPC_RESET;
		end else if (wr_en) begin
			unique case (index)
				REG_CLUSTER_COUNT:       cfg_q.cluster_count       <= pwdata[CC_W-1:0];
				REG_DATA_START_SECTOR:   cfg_q.data_start_sector   <= pwdata[DSS_W-1:0];
				REG_SECTORS_PER_CLUSTER: cfg_q.sectors_per_cluster <= pwdata[SPC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (index)
			REG_CLUSTER_COUNT:       prdata = APB_DATA_W'(cfg_q.cluster_count);
			REG_DATA_START_SECTOR:   prdata = APB_DATA_W'(cfg_q.data_start_sector);
			REG_SECTORS_PER_CLUSTER: prdata = APB_DATA_W'(cfg_q.sectors_per_cluster);
			default:                 prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

[rtl/fcca_ctrl.sv]
// Command sequencer: clear pass, decode, scan, link and chain walk control.
// Depends on fcca_pkg; drives fcca_dpath through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module fcca_ctrl import fcca_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire dp_stat_t ds,
	output dp_cmd_t       dc
);

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_START = 7'b0000100,
		S_COUNT = 7'b0001000,
		S_LINK  = 7'b0010000,
		S_READ  = 7'b0100000,
		S_WALK  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		dc.op        = OP_NOP;
		dc.load_item = 1'b0;
		dc.res_load  = 1'b0;
		dc.kind      = RK_BAD;
		unique case (state_q)
			S_CLEAR: begin
				dc.op = OP_CLEAR;
				if (ds.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					dc.load_item = 1'b1;
					state_d      = S_START;
				end
			end
			S_START: begin
				// hold until the output register is free
				if (!out_valid_q) begin
					dc.op = OP_START;
					unique case (ds.command)
						CMD_ALLOC: begin
							if (ds.count_zero) begin
								dc.res_load = 1'b1;
								state_d     = S_IDLE;
							end else begin
								state_d = S_COUNT;
							end
						end
						CMD_FREE: begin
							if (!ds.arg_ok) begin
								dc.res_load = 1'b1;
								state_d     = S_IDLE;
							end else begin
								state_d = S_WALK;
							end
						end
						CMD_READ: begin
							if (!ds.arg_ok) begin
								dc.res_load = 1'b1;
								state_d     = S_IDLE;
							end else begin
								state_d = S_READ;
							end
						end
						CMD_WRITE: begin
							dc.res_load = 1'b1;
							dc.kind     = ds.arg_ok ? RK_WRITE : RK_BAD;
							state_d     = S_IDLE;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_COUNT: begin
				priority if (ds.enough) begin
					dc.op   = OP_RESCAN;
					state_d = S_LINK;
				end else if (ds.scan_done) begin
					dc.res_load = 1'b1;
					dc.kind     = RK_NOSPACE;
					state_d     = S_IDLE;
				end else begin
					dc.op = OP_COUNT;
				end
			end
			S_LINK: begin
				if (ds.enough) begin
					dc.op       = OP_LINK_END;
					dc.res_load = 1'b1;
					dc.kind     = RK_ALLOC;
					state_d     = S_IDLE;
				end else begin
					dc.op = OP_LINK;
				end
			end
			S_READ: begin
				dc.res_load = 1'b1;
				dc.kind     = RK_READ;
				state_d     = S_IDLE;
			end
			S_WALK: begin
				dc.op = OP_WALK;
				priority if (ds.walk_over) begin
					dc.res_load = 1'b1;
					dc.kind     = RK_BROKEN;
					state_d     = S_IDLE;
				end else if (ds.walk_end) begin
					dc.res_load = 1'b1;
					dc.kind     = RK_FREED;
					state_d     = S_IDLE;
				end else if (ds.walk_bad) begin
					dc.res_load = 1'b1;
					dc.kind     = RK_BROKEN;
					state_d     = S_IDLE;
				end else begin
					state_d = S_WALK;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (dc.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/fcca_dpath.sv]
// Datapath: link table memory, scan and walk counters, sector math, result register.
// Depends on fcca_pkg; sequenced by fcca_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module fcca_dpath import fcca_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cfg_t                  cfg,
	input  wire dp_cmd_t               dc,
	output dp_stat_t                   ds,
	input  wire logic [CMD_W-1:0]      in_command,
	input  wire logic [CLUSTER_W-1:0]  in_cluster,
	input  wire logic [COUNT_W-1:0]    in_count,
	input  wire logic [LINK_W-1:0]     in_link_value,
	output logic      [STATUS_W-1:0]   res_status,
	output logic      [CLUSTER_W-1:0]  res_cluster,
	output logic      [LINK_W-1:0]     res_link,
	output logic      [SECTOR_W-1:0]   res_sector,
	output logic      [DONE_W-1:0]     res_done
);

	logic [LINK_W-1:0] mem [TABLE_ENTRIES];

	// Memory ports
	logic              we;
	logic [IDX_W-1:0]  waddr, raddr;
	logic [LINK_W-1:0] wdata, rdata_q, rdata;
	logic              fwd_s1;
	logic [LINK_W-1:0] fwd_data_s1;

	// Item registers
	logic [CMD_W-1:0]     command_q;
	logic [CLUSTER_W-1:0] cluster_q;
	logic [COUNT_W-1:0]   count_q;
	logic [LINK_W-1:0]    link_q;

	// Scan and walk state
	logic [IDX_W-1:0]    clr_q;
	logic [CNT_W-1:0]    ptr_q;
	logic                rv_s1;
	logic [IDX_W-1:0]    ra_s1;
	logic [CNT_W-1:0]    cnt_q;
	logic [IDX_W-1:0]    first_q, prev_q, cur_q;
	logic [SECTOR_W-1:0] sector_q;

	// Result register
	status_t              res_status_q;
	logic [CLUSTER_W-1:0] res_cluster_q;
	logic [LINK_W-1:0]    res_link_q;
	logic [SECTOR_W-1:0]  res_sector_q;
	logic [DONE_W-1:0]    res_done_q;

	logic [CNT_W-1:0]    n_use;
	logic                arg_ok, scan_issue, hit, link_take, v_ok, walk_over, walk_go;
	logic [IDX_W-1:0]    diff;
	logic [SECTOR_W-1:0] prod;
	logic [SECTOR_W:0]   sum;
	logic [SECTOR_W-1:0] sector_calc;

	// Entries in use: the smaller of the register and the table depth
	assign n_use = (CNT_W'(cfg.cluster_count) > CNT_W'(TABLE_ENTRIES)) ?
		CNT_W'(TABLE_ENTRIES) : CNT_W'(cfg.cluster_count);

	assign rdata      = fwd_s1 ? fwd_data_s1 : rdata_q;
	assign arg_ok     = (cluster_q >= CLUSTER_W'(2)) && (CNT_W'(cluster_q) < n_use);
	assign scan_issue = ((dc.op == OP_COUNT) || (dc.op == OP_LINK)) && (ptr_q < n_use);
	assign hit        = rv_s1 && (rdata == FREE_MARK);
	assign link_take  = (dc.op == OP_LINK) && hit && (CNT_W'(count_q) > cnt_q);
	assign v_ok       = (rdata >= LINK_W'(2)) && (rdata < LINK_W'(n_use));
	assign walk_over  = (cnt_q >= (n_use - CNT_W'(2)));
	assign walk_go    = (dc.op == OP_WALK) && !walk_over && (rdata != END_MARK) && v_ok;

	// Sector of a cluster: start + spc * (cluster - 2), saturated
	assign diff        = IDX_W'(cluster_q) - IDX_W'(2);
	assign prod        = SECTOR_W'(cfg.sectors_per_cluster) * SECTOR_W'(diff);
	assign sum         = (SECTOR_W+1)'(cfg.data_start_sector) + (SECTOR_W+1)'(prod);
	assign sector_calc = sum[SECTOR_W] ? SECTOR_MAX : sum[SECTOR_W-1:0];

	assign ds.command    = cmd_code_t'(command_q);
	assign ds.arg_ok     = arg_ok;
	assign ds.count_zero = (count_q == '0);
	assign ds.clr_last   = (clr_q == IDX_W'(TABLE_ENTRIES - 1));
	assign ds.enough     = (cnt_q == CNT_W'(count_q));
	assign ds.scan_done  = !rv_s1 && (ptr_q >= n_use);
	assign ds.walk_over  = walk_over;
	assign ds.walk_end   = (rdata == END_MARK);
	assign ds.walk_bad   = !v_ok;

	// Memory port selection
	always_comb begin
		we    = 1'b0;
		waddr = cur_q;
		wdata = FREE_MARK;
		raddr = ptr_q[IDX_W-1:0];
		unique case (dc.op)
			OP_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
			end
			OP_START: begin
				we    = (command_q == CMD_WRITE) && arg_ok;
				waddr = IDX_W'(cluster_q);
				wdata = link_q;
				raddr = IDX_W'(cluster_q);
			end
			OP_LINK: begin
				we    = link_take && (cnt_q != '0);
				waddr = prev_q;
				wdata = LINK_W'(ra_s1);
			end
			OP_LINK_END: begin
				we    = 1'b1;
				waddr = prev_q;
				wdata = END_MARK;
			end
			OP_WALK: begin
				we    = !walk_over && ((rdata == END_MARK) || v_ok);
				waddr = cur_q;
				raddr = rdata[IDX_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q     <= mem[raddr];
		fwd_data_s1 <= wdata;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			rv_s1  <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			// a read of the address written in the same cycle sees the new word
			fwd_s1 <= we && (waddr == raddr);
			rv_s1  <= scan_issue;
			if (dc.op == OP_CLEAR) clr_q <= clr_q + IDX_W'(1);
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (dc.load_item) begin
			command_q <= in_command;
			cluster_q <= in_cluster;
			count_q   <= in_count;
			link_q    <= in_link_value;
		end
		ra_s1 <= ptr_q[IDX_W-1:0];
		if (scan_issue) ptr_q <= ptr_q + CNT_W'(1);
		unique case (dc.op)
			OP_START: begin
				ptr_q    <= CNT_W'(2);
				cnt_q    <= '0;
				first_q  <= '0;
				cur_q    <= IDX_W'(cluster_q);
				sector_q <= sector_calc;
			end
			OP_RESCAN: begin
				ptr_q <= CNT_W'(2);
				cnt_q <= '0;
			end
			OP_COUNT: begin
				if (hit) cnt_q <= cnt_q + CNT_W'(1);
			end
			OP_LINK: begin
				if (link_take) begin
					cnt_q  <= cnt_q + CNT_W'(1);
					prev_q <= ra_s1;
					if (cnt_q == '0) first_q <= ra_s1;
				end
			end
			OP_WALK: begin
				if (walk_go) begin
					cnt_q <= cnt_q + CNT_W'(1);
					cur_q <= rdata[IDX_W-1:0];
				end
			end
			default: ;
		endcase

		if (dc.res_load) begin
			unique case (dc.kind)
				RK_BAD:     res_status_q <= ST_BAD_ARG;
				RK_NOSPACE: res_status_q <= ST_NO_SPACE;
				RK_BROKEN:  res_status_q <= ST_BROKEN;
				default:    res_status_q <= ST_OK;
			endcase
			if (command_q == CMD_ALLOC) begin
				res_cluster_q <= (dc.kind == RK_ALLOC) ? CLUSTER_W'(first_q) : '0;
			end else begin
				res_cluster_q <= cluster_q;
			end
			unique case (dc.kind)
				RK_READ:  res_link_q <= rdata;
				RK_WRITE: res_link_q <= link_q;
				default:  res_link_q <= FREE_MARK;
			endcase
			res_sector_q <= (dc.kind == RK_READ) ? sector_q : '0;
			unique case (dc.kind)
				RK_ALLOC, RK_BROKEN: res_done_q <= DONE_W'(cnt_q);
				RK_FREED:            res_done_q <= DONE_W'(cnt_q + CNT_W'(1));
				default:             res_done_q <= '0;
			endcase
		end
	end

	assign res_status  = res_status_q;
	assign res_cluster = res_cluster_q;
	assign res_link    = res_link_q;
	assign res_sector  = res_sector_q;
	assign res_done    = res_done_q;

endmodule

`default_nettype wire

[rtl/fat_cluster_chain_allocator_unit.sv]
// Top level of the cluster chain allocator: APB registers, sequencer and datapath.
// Depends on fcca_pkg, fcca_channels, fcca_regs, fcca_ctrl and fcca_dpath.
`timescale 1ns / 1ps
`default_nettype none

// Cluster chain allocator. Holds a 1024-entry table of 28-bit link words (0 = free,
// 0x0FFFFFFF = end of chain) and runs one command per transfer on the cmd channel, giving
// exactly one result transfer on the res channel. After reset the block sweeps the
// whole table to free, one entry per cycle, and cmd.ready stays low until the sweep
// ends; APB writes are taken throughout. Commands run one at a time; free walks the
// chain one link per cycle, and allocate makes two passes over the single table read
// port, one counting free entries and one linking them, each at one entry per cycle and
// each ending as soon as enough free clusters are found. The next command is accepted
// while a result still waits on res; its work starts once that result has been taken.
// Write configuration only while no command is in flight.
module fat_cluster_chain_allocator_unit import fcca_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	fcca_cmd_if.sink                   cmd,
	fcca_res_if.source                 res,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready
);

	cfg_t     cfg;
	dp_cmd_t  dc;
	dp_stat_t ds;

	// Configuration registers
	fcca_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer: owns both handshakes, tells the datapath what to do each cycle
	fcca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.ds        (ds),
		.dc        (dc)
	);

	// Datapath: table memory, counters and the result register
	fcca_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.dc            (dc),
		.ds            (ds),
		.in_command    (cmd.command),
		.in_cluster    (cmd.cluster),
		.in_count      (cmd.count),
		.in_link_value (cmd.link_value),
		.res_status    (res.status),
		.res_cluster   (res.result_cluster),
		.res_link      (res.result_link),
		.res_sector    (res.sector),
		.res_done      (res.done_count)
	);

endmodule

`default_nettype wire

[sim/fat_cluster_chain_allocator_unit_tb.sv]
// Self-checking testbench for the FAT cluster chain allocator.
// Depends on fcca_pkg, fcca_channels and fat_cluster_chain_allocator_unit.
`timescale 1ns / 1ps

module fat_cluster_chain_allocator_unit_tb;
	import fcca_pkg::*;

	// Slowest correct item: an allocate scans the table twice, plus sender gap and
	// receiver stall. The limit covers about 600 items of that kind plus the clear sweep
	// after reset, with a threefold margin.
	localparam int unsigned CYCLE_LIMIT = 4_000_000;

	typedef struct packed {
		cmd_code_t            command;
		logic [CLUSTER_W-1:0] cluster;
		logic [COUNT_W-1:0]   count;
		logic [LINK_W-1:0]    link_value;
	} op_t;

	typedef struct packed {
		status_t              status;
		logic [CLUSTER_W-1:0] cluster;
		logic [LINK_W-1:0]    link;
		logic [SECTOR_W-1:0]  sector;
		logic [DONE_W-1:0]    done;
	} outcome_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	fcca_cmd_if cmd_ch ();
	fcca_res_if res_ch ();

	fat_cluster_chain_allocator_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow of the allocation table and of the configuration registers
	logic [LINK_W-1:0] fat [TABLE_ENTRIES];
	logic [CC_W-1:0]   cfg_cc;
	logic [DSS_W-1:0]  cfg_dss;
	logic [SPC_W-1:0]  cfg_spc;

	op_t         pending_ops[$];       // commands not yet transferred
	outcome_t    expected_results[$];  // predictions waiting for their result transfer
	int          chain_heads[$];       // starts of chains handed out by allocate
	bit          idle_en;
	int          send_gap;
	int          stall_left;
	int          fault_count;
	int unsigned cycle_count;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int span();
		return (cfg_cc > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(cfg_cc);
	endfunction

	function automatic bit in_range(input int unsigned c, input int n);
		return c >= 2 && c < n;
	endfunction

	// Execute one command on the shadow table and return the result it must give.
	function automatic outcome_t fat_execute(input op_t op);
		int          n;
		int          i;
		int          avail;
		int          linked;
		int          first;
		int          prev;
		int          cur;
		int          freed;
		int unsigned sec;
		logic [LINK_W-1:0] v;
		outcome_t    r;
		r = '0;
		n = span();
		case (op.command)
			CMD_ALLOC: begin
				if (op.count == 0) begin
					r.status = ST_BAD_ARG;
				end else begin
					avail = 0;
					for (i = 2; i < n; i++)
						if (fat[i] == FREE_MARK)
							avail++;
					if (avail < int'(op.count)) begin
						r.status = ST_NO_SPACE;
					end else begin
						// link the lowest free entries in ascending order
						linked = 0;
						first = 0;
						prev = 0;
						for (i = 2; i < n && linked < int'(op.count); i++) begin
							if (fat[i] == FREE_MARK) begin
								if (linked == 0)
									first = i;
								else
									fat[prev] = LINK_W'(i);
								prev = i;
								linked++;
							end
						end
						fat[prev] = END_MARK;
						r.status = ST_OK;
						r.cluster = CLUSTER_W'(first);
						r.done = DONE_W'(linked);
					end
				end
			end
			CMD_FREE: begin
				r.cluster = op.cluster;
				if (!in_range(op.cluster, n)) begin
					r.status = ST_BAD_ARG;
				end else begin
					// a walk that runs past n-2 entries or meets a bad link is broken
					cur = op.cluster;
					freed = 0;
					r.status = ST_BROKEN;
					while (freed < n - 2) begin
						v = fat[cur];
						if (v == END_MARK) begin
							fat[cur] = FREE_MARK;
							freed++;
							r.status = ST_OK;
							break;
						end
						if (!in_range(v, n))
							break;
						fat[cur] = FREE_MARK;
						freed++;
						cur = v;
					end
					r.done = DONE_W'(freed);
				end
			end
			CMD_READ: begin
				r.cluster = op.cluster;
				if (!in_range(op.cluster, n)) begin
					r.status = ST_BAD_ARG;
				end else begin
					sec = int'(cfg_dss) + int'(cfg_spc) * (int'(op.cluster) - 2);
					if (sec > int'(SECTOR_MAX))
						sec = SECTOR_MAX;
					r.status = ST_OK;
					r.link = fat[op.cluster];
					r.sector = SECTOR_W'(sec);
				end
			end
			default: begin
				r.cluster = op.cluster;
				if (!in_range(op.cluster, n)) begin
					r.status = ST_BAD_ARG;
				end else begin
					fat[op.cluster] = op.link_value;
					r.status = ST_OK;
					r.link = op.link_value;
				end
			end
		endcase
		return r;
	endfunction

	function automatic op_t make_op(input cmd_code_t command, input int cluster, input int count,
			input logic [LINK_W-1:0] link_value);
		op_t op;
		op.command = command;
		op.cluster = CLUSTER_W'(cluster);
		op.count = COUNT_W'(count);
		op.link_value = link_value;
		return op;
	endfunction

	// Append one command to the send queue.
	task automatic queue_op(input op_t op);
		pending_ops = {pending_ops, op};
	endtask

	// Random command, weighted toward well-formed traffic: frees mostly target live chains,
	// reads and writes mostly hit valid clusters.
	function automatic op_t random_op();
		int  n;
		int  pick;
		int  idx;
		op_t op;
		n = span();
		pick = $urandom_range(0, 99);
		op.cluster = CLUSTER_W'($urandom_range(0, 1023));
		op.count = COUNT_W'($urandom_range(0, 2047));
		op.link_value = LINK_W'($urandom);
		if (pick < 35) begin
			op.command = CMD_ALLOC;
			case ($urandom_range(0, 19))
				0: op.count = '0;
				1: ;
				2: op.count = COUNT_W'($urandom_range(1, n));
				default: op.count = COUNT_W'($urandom_range(1, 8));
			endcase
		end else if (pick < 60) begin
			op.command = CMD_FREE;
			if (chain_heads.size() > 0 && $urandom_range(0, 4) != 0) begin
				idx = $urandom_range(0, chain_heads.size() - 1);
				op.cluster = CLUSTER_W'(chain_heads[idx]);
				chain_heads.delete(idx);
			end else if ($urandom_range(0, 1) == 0) begin
				op.cluster = CLUSTER_W'($urandom_range(2, n - 1));
			end
		end else if (pick < 85) begin
			op.command = CMD_READ;
			if ($urandom_range(0, 4) != 0)
				op.cluster = CLUSTER_W'($urandom_range(2, n - 1));
		end else begin
			op.command = CMD_WRITE;
			if ($urandom_range(0, 6) != 0)
				op.cluster = CLUSTER_W'($urandom_range(2, n - 1));
			case ($urandom_range(0, 5))
				0, 1: op.link_value = LINK_W'($urandom_range(2, n - 1));
				2: op.link_value = END_MARK;
				3: op.link_value = FREE_MARK;
				4: op.link_value = END_MARK - 1;
				default: ;
			endcase
		end
		return op;
	endfunction

	// Hold the sender until every outstanding result has been transferred.
	task automatic drain();
		while (pending_ops.size() > 0 || expected_results.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle; the register takes the value at the
	// edge that closes the access cycle.
	task automatic reg_write(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_CLUSTER_COUNT:       cfg_cc = value[CC_W-1:0];
			REG_DATA_START_SECTOR:   cfg_dss = value[DSS_W-1:0];
			REG_SECTORS_PER_CLUSTER: cfg_spc = value[SPC_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(input int cc, input int dss, input int spc);
		drain();
		reg_write(REG_CLUSTER_COUNT, APB_DATA_W'(cc));
		reg_write(REG_DATA_START_SECTOR, APB_DATA_W'(dss));
		reg_write(REG_SECTORS_PER_CLUSTER, APB_DATA_W'(spc));
	endtask

	// Feed random commands a few at a time so frees see up-to-date chain heads.
	task automatic random_items(input int total);
		int k;
		for (k = 0; k < total; k++) begin
			while (pending_ops.size() > 2)
				@(posedge clk);
			queue_op(random_op());
			if ($urandom_range(0, 29) == 0)
				drain();
		end
	endtask

	// Command driver: advance to the next queued command after each transfer, with
	// random idle bursts between commands while idling is enabled.
	always @(posedge clk) begin
		bit       fire;
		op_t      op;
		outcome_t want;
		fire = cmd_ch.valid && cmd_ch.ready;
		if (fire) begin
			op.command = cmd_code_t'(cmd_ch.command);
			op.cluster = cmd_ch.cluster;
			op.count = cmd_ch.count;
			op.link_value = cmd_ch.link_value;
			want = fat_execute(op);
			expected_results = {expected_results, want};
			if (op.command == CMD_ALLOC && want.status == ST_OK)
				chain_heads = {chain_heads, int'(want.cluster)};
			void'(pending_ops.pop_front());
		end
		// hold the current command until it is taken
		if (fire || !cmd_ch.valid) begin
			if (send_gap > 0) begin
				send_gap--;
				cmd_ch.valid <= 1'b0;
			end else if (pending_ops.size() > 0) begin
				cmd_ch.valid <= 1'b1;
				cmd_ch.command <= pending_ops[0].command;
				cmd_ch.cluster <= pending_ops[0].cluster;
				cmd_ch.count <= pending_ops[0].count;
				cmd_ch.link_value <= pending_ops[0].link_value;
				if (idle_en && $urandom_range(0, 7) == 0)
					send_gap = $urandom_range(1, 15);
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// Result monitor: compare each result transfer with the oldest prediction, and drop
	// ready in random bursts while idling is enabled.
	always @(posedge clk) begin
		outcome_t seen;
		outcome_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			seen.status = status_t'(res_ch.status);
			seen.cluster = res_ch.result_cluster;
			seen.link = res_ch.result_link;
			seen.sector = res_ch.sector;
			seen.done = res_ch.done_count;
			if (expected_results.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("result with nothing expected: st=%0d cl=%0d link=%h sec=%0d done=%0d",
						seen.status, seen.cluster, seen.link, seen.sector, seen.done);
			end else begin
				want = expected_results.pop_front();
				if (seen.status !== want.status || seen.cluster !== want.cluster ||
						seen.link !== want.link || seen.sector !== want.sector ||
						seen.done !== want.done) begin
					fault_count++;
					if (fault_count <= 10) begin
						$display("result mismatch at %0t:", $realtime);
						$display("  exp st=%0d cl=%0d link=%h sec=%0d done=%0d",
							want.status, want.cluster, want.link, want.sector, want.done);
						$display("  got st=%0d cl=%0d link=%h sec=%0d done=%0d",
							seen.status, seen.cluster, seen.link, seen.sector, seen.done);
					end
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
			if (idle_en && $urandom_range(0, 9) == 0)
				stall_left = $urandom_range(1, 15);
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int i;
		// known levels on every input from time zero
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = '0;
		cmd_ch.cluster = '0;
		cmd_ch.count = '0;
		cmd_ch.link_value = '0;
		res_ch.ready = 1'b0;
		idle_en = 1'b1;
		send_gap = 0;
		stall_left = 0;
		fault_count = 0;
		cycle_count = 0;
		for (i = 0; i < TABLE_ENTRIES; i++)
			fat[i] = FREE_MARK;
		cfg_cc = CC_RESET;
		cfg_dss = DSS_RESET;
		cfg_spc = SPC_RESET;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed checks on reset configuration; the table starts all free.
		queue_op(make_op(CMD_ALLOC, 0, 0, 0));          // zero count
		queue_op(make_op(CMD_ALLOC, 0, 1, 0));          // chain {2}
		queue_op(make_op(CMD_ALLOC, 0, 3, 0));          // chain {3,4,5}
		queue_op(make_op(CMD_READ, 2, 0, 0));
		queue_op(make_op(CMD_READ, 3, 0, 0));
		queue_op(make_op(CMD_READ, 0, 0, 0));           // below range
		queue_op(make_op(CMD_READ, 1, 0, 0));
		queue_op(make_op(CMD_READ, 1023, 2047, '1));    // top cluster
		queue_op(make_op(CMD_WRITE, 1, 0, END_MARK));   // below range
		queue_op(make_op(CMD_WRITE, 1023, 0, END_MARK));
		queue_op(make_op(CMD_FREE, 1023, 0, 0));
		queue_op(make_op(CMD_FREE, 3, 0, 0));
		queue_op(make_op(CMD_FREE, 2, 0, 0));
		queue_op(make_op(CMD_FREE, 0, 0, 0));           // below range
		queue_op(make_op(CMD_FREE, 10, 0, 0));          // walk starts on a free entry
		// link out of range in mid-chain; one below the end mark is not an end mark
		queue_op(make_op(CMD_WRITE, 20, 0, 21));
		queue_op(make_op(CMD_WRITE, 21, 0, END_MARK - 1));
		queue_op(make_op(CMD_FREE, 20, 0, 0));
		queue_op(make_op(CMD_READ, 21, 0, 0));
		// loop closes back on an entry already freed
		queue_op(make_op(CMD_WRITE, 30, 0, 31));
		queue_op(make_op(CMD_WRITE, 31, 0, 30));
		queue_op(make_op(CMD_FREE, 30, 0, 0));
		queue_op(make_op(CMD_ALLOC, 0, 1024, 0));       // too few free
		queue_op(make_op(CMD_ALLOC, 0, 2047, 0));

		// Four entries, largest start sector, 128 sectors per cluster: a full-table loop trips
		// the walk limit, and entries above the range stay out of reach.
		configure(4, 65535, 128);
		queue_op(make_op(CMD_WRITE, 2, 0, 3));
		queue_op(make_op(CMD_WRITE, 3, 0, 2));
		queue_op(make_op(CMD_FREE, 2, 0, 0));
		queue_op(make_op(CMD_READ, 1023, 0, 0));
		random_items(36);

		// Three entries: a single usable cluster.
		configure(3, 0, 1);
		random_items(40);

		configure(1024, $urandom_range(0, 65535), $urandom_range(1, 128));
		random_items(120);

		configure($urandom_range(5, 64), $urandom_range(0, 65535), $urandom_range(1, 128));
		random_items(100);

		// full table, largest start sector, 128 sectors per cluster, back to back with no idling
		configure(1024, 65535, 128);
		idle_en = 1'b0;
		random_items(80);

		configure($urandom_range(65, 1024), $urandom_range(0, 65535), $urandom_range(1, 128));
		idle_en = 1'b1;
		random_items(100);

		// closing stretch runs at full rate on both sides
		configure($urandom_range(5, 200), $urandom_range(0, 65535), $urandom_range(1, 128));
		idle_en = 1'b0;
		random_items(100);

		drain();
		repeat (50) @(posedge clk);
		if (fault_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[fat_cluster_chain_allocator_unit.f]
rtl/fcca_pkg.sv
rtl/fcca_channels.sv
rtl/fcca_regs.sv
rtl/fcca_ctrl.sv
rtl/fcca_dpath.sv
rtl/fat_cluster_chain_allocator_unit.sv
sim/fat_cluster_chain_allocator_unit_tb.sv
